FILE: hdl/encoder_speed_pi_frequency_control_unit_macros.svh
// assertion macros for the encoder speed pi frequency control unit
`ifndef ENCODER_SPEED_PI_FREQUENCY_CONTROL_UNIT_MACROS_SVH
`define ENCODER_SPEED_PI_FREQUENCY_CONTROL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define ESFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define ESFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ESFC_ASSERT(lbl, prop, msg)
`define ESFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/esfc_pkg.sv
package esfc_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CTRL = 1'b1;

	localparam logic [1:0] LEVEL_KEEP = 2'd3;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_TGT_LOW,
		REG_TGT_MID,
		REG_TGT_HIGH,
		REG_FRQ_LOW,
		REG_FRQ_MID,
		REG_FRQ_HIGH
	} reg_idx_t;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] encoder_count;
		logic [1:0]         speed_level;
		logic               run_enable;
	} item_t;

	typedef struct packed {
		logic [15:0] drive_freq;
		logic [30:0] measured_speed;
	} result_t;

endpackage

FILE: hdl/esfc_stream_if.sv
interface esfc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/encoder_speed_pi_frequency_control_unit.sv
// Encoder speed measurement with a velocity-form PI loop on the drive frequency. Tick beats
// (opcode 0) carry an encoder reading and give no result; control beats (opcode 1) give one
// result with the new drive frequency and the latest window speed (Q16). A beat is taken
// every cycle while the output is not stalled and no window tick holds it off; a control
// result goes from the input register through stages 2 and 3 to the output register. The
// tick that closes a speed window holds the input off while it waits in the input register
// and during the reciprocal multiplication for the speed. Configuration writes go straight
// into the register file, each target as target/100 in Q16. Reset needs no clearing pass.
`include "encoder_speed_pi_frequency_control_unit_macros.svh"

module encoder_speed_pi_frequency_control_unit
	import esfc_pkg::*;
#(
	parameter int unsigned WINDOW_TICKS = 100,
	parameter int unsigned FREQ_MAX     = 5000,
	parameter int unsigned KP_GAIN      = 1400,
	parameter int unsigned KI_GAIN      = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	esfc_stream_if.sink       item,
	esfc_stream_if.source     result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam logic [30:0] RECIP25 = 31'd1374389535;
	localparam logic signed [16:0] KP_S = 17'(KP_GAIN);
	localparam logic signed [16:0] KI_S = 17'(KI_GAIN);
	localparam logic signed [15:0] I_LIM = 16'sd16384;

	// speed: floor(mag * 0.52 * 65536 / window) as mag times a reciprocal scaled by 2^35
	localparam int unsigned SPD_DIV   = 25 * WINDOW_TICKS;
	localparam logic [63:0] SPD_RCP   = ((64'd13 << 51) + 64'(SPD_DIV) - 64'd1) / 64'(SPD_DIV);
	localparam logic [25:0] SPD_RCP_L = SPD_RCP[25:0];
	localparam logic [25:0] SPD_RCP_H = SPD_RCP[51:26];

	// configuration
	logic        mode_q;
	logic [25:0] tgt_tab_q [3];
	logic [15:0] frq_tab_q [3];

	logic [32:0] tgt_num;
	logic [61:0] tgt_prod;
	logic [25:0] tgt_calc;

	always_comb begin
		tgt_num  = {1'b0, cfg_data, 16'd0} + 33'd50;
		tgt_prod = 62'(tgt_num[32:2]) * 62'(RECIP25);
		tgt_calc = tgt_prod[60:35];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tgt_tab_q[i] <= '0;
				frq_tab_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:     mode_q       <= cfg_data[0];
				REG_TGT_LOW:  tgt_tab_q[0] <= tgt_calc;
				REG_TGT_MID:  tgt_tab_q[1] <= tgt_calc;
				REG_TGT_HIGH: tgt_tab_q[2] <= tgt_calc;
				REG_FRQ_LOW:  frq_tab_q[0] <= cfg_data;
				REG_FRQ_MID:  frq_tab_q[1] <= cfg_data;
				REG_FRQ_HIGH: frq_tab_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic  valid_s1, valid_s2, valid_s3;
	item_t item_s1;
	logic  advance;
	logic  accept;
	logic  win_end;
	logic  div_busy_q;
	logic  out_valid_q;
	result_t out_q;

	assign advance    = !(valid_s3 && out_valid_q && !result.ready);
	assign item.ready = advance && !div_busy_q &&
		!(valid_s1 && item_s1.opcode == OP_TICK && win_end);
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
		end
	end

	// encoder window
	logic [15:0] prev_enc_q;
	logic [6:0]  ticks_q;
	logic signed [22:0] wsum_q;
	logic [30:0] speed_q;

	logic signed [15:0] inc;
	logic signed [22:0] sum_nxt;
	logic [7:0]  tick_nxt;
	logic [22:0] mag;
	logic        tick_fire;

	always_comb begin
		inc       = $signed(prev_enc_q - item_s1.encoder_count);
		sum_nxt   = wsum_q + 23'(inc);
		tick_nxt  = {1'b0, ticks_q} + 8'd1;
		win_end   = tick_nxt >= 8'(WINDOW_TICKS);
		mag       = sum_nxt[22] ? 23'(-sum_nxt) : 23'(sum_nxt);
		tick_fire = valid_s1 && advance && item_s1.opcode == OP_TICK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_enc_q <= '0;
			ticks_q    <= '0;
			wsum_q     <= '0;
		end else if (tick_fire) begin
			prev_enc_q <= item_s1.encoder_count;
			if (win_end) begin
				ticks_q <= '0;
				wsum_q  <= '0;
			end else begin
				ticks_q <= tick_nxt[6:0];
				wsum_q  <= sum_nxt;
			end
		end
	end

	// speed scaling: two partial products, then their sum
	logic [22:0] mag_q;
	logic [48:0] plo_q, phi_q;
	logic        cnt_q;
	logic [75:0] spd_sum;

	always_comb begin
		spd_sum = 76'({phi_q, 26'd0}) + 76'(plo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q      <= 1'b0;
			speed_q    <= '0;
		end else if (div_busy_q) begin
			cnt_q <= 1'b1;
			if (cnt_q) begin
				div_busy_q <= 1'b0;
				speed_q    <= spd_sum[65:35];
			end
		end else if (tick_fire && win_end) begin
			div_busy_q <= 1'b1;
			cnt_q      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_busy_q) begin
			if (!cnt_q) begin
				plo_q <= 49'(mag_q) * 49'(SPD_RCP_L);
				phi_q <= 49'(mag_q) * 49'(SPD_RCP_H);
			end
		end else if (tick_fire && win_end) begin
			mag_q <= mag;
		end
	end

	// control step: error and integral
	logic [25:0] target_q;
	logic signed [31:0] err_q;
	logic signed [15:0] integral_q;

	logic        ctrl_fire;
	logic        level_ok;
	logic [25:0] tgt_new;
	logic signed [31:0] e;
	logic [31:0] ae;
	logic [15:0] ai;
	logic        e_small, hold, flip, done;
	logic signed [16:0] isum;
	logic signed [15:0] icl, i_used, i_store;
	logic        open_keep;
	logic [15:0] open_val;

	always_comb begin
		ctrl_fire = valid_s1 && advance && item_s1.opcode == OP_CTRL;
		level_ok  = item_s1.speed_level != LEVEL_KEEP;
		tgt_new   = level_ok ? tgt_tab_q[item_s1.speed_level] : target_q;
		if (!item_s1.run_enable) begin
			tgt_new = '0;
		end
		e       = $signed({6'd0, tgt_new}) - $signed({1'b0, speed_q});
		ae      = e[31] ? 32'(-e) : 32'(e);
		ai      = integral_q[15] ? 16'(-integral_q) : 16'(integral_q);
		e_small = ae <= 32'd16384;
		hold    = e_small && ai >= 16'd16384 &&
			((integral_q > 0 && e > 0) || (integral_q < 0 && e < 0));
		isum    = 17'(integral_q) + $signed(e[16:0]);
		if (isum >= 17'sd16384) begin
			icl = I_LIM;
		end else if (isum <= -17'sd16384) begin
			icl = -I_LIM;
		end else begin
			icl = isum[15:0];
		end
		flip    = (err_q > 0 && e < 0) || (err_q < 0 && e > 0);
		if (hold) begin
			i_used = integral_q;
		end else if (flip || !e_small) begin
			i_used = '0;
		end else begin
			i_used = icl;
		end
		done      = ae <= 32'd65;
		i_store   = done ? 16'sd0 : i_used;
		open_keep = item_s1.run_enable && !level_ok;
		open_val  = (item_s1.run_enable && level_ok) ? frq_tab_q[item_s1.speed_level] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			err_q      <= '0;
			integral_q <= '0;
		end else if (ctrl_fire && mode_q) begin
			target_q   <= tgt_new;
			err_q      <= e;
			integral_q <= i_store;
		end
	end

	// stage 2: gain products
	logic               closed_s2, keep_s2;
	logic [15:0]        oval_s2;
	logic signed [31:0] e_s2;
	logic signed [15:0] i_s2;
	logic [30:0]        spd_s2;

	logic               closed_s3, keep_s3;
	logic [15:0]        oval_s3;
	logic signed [48:0] pkp_s3;
	logic signed [32:0] pki_s3;
	logic [30:0]        spd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && item_s1.opcode == OP_CTRL;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			closed_s2 <= mode_q;
			keep_s2   <= open_keep;
			oval_s2   <= open_val;
			e_s2      <= e;
			i_s2      <= i_used;
			spd_s2    <= speed_q;

			closed_s3 <= closed_s2;
			keep_s3   <= keep_s2;
			oval_s3   <= oval_s2;
			pkp_s3    <= 49'(e_s2) * 49'(KP_S);
			pki_s3    <= 33'(i_s2) * 33'(KI_S);
			spd_s3    <= spd_s2;
		end
	end

	// stage 3: frequency update
	logic [15:0]        freq_q;
	logic signed [49:0] acc;
	logic [15:0]        freq_pi, freq_nxt;

	always_comb begin
		acc = $signed({18'd0, freq_q, 16'd0}) + 50'(pkp_s3) + 50'(pki_s3);
		if (acc[49]) begin
			freq_pi = '0;
		end else if (acc[48:16] > 33'(FREQ_MAX)) begin
			freq_pi = 16'(FREQ_MAX);
		end else begin
			freq_pi = acc[31:16];
		end
		if (closed_s3) begin
			freq_nxt = freq_pi;
		end else if (keep_s3) begin
			freq_nxt = freq_q;
		end else begin
			freq_nxt = oval_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s3 && advance) begin
			freq_q      <= freq_nxt;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && advance) begin
			out_q.drive_freq     <= freq_nxt;
			out_q.measured_speed <= spd_s3;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	`ESFC_ASSERT(a_no_take_while_div, item.ready |-> !div_busy_q, "beat taken while divider busy")
	`ESFC_ASSERT(a_freq_clamped, (valid_s3 && advance && closed_s3) |=> (freq_q <= 16'(FREQ_MAX)), "closed loop frequency above limit")
	`ESFC_ASSERT(a_out_hold, (out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_q)), "pending result lost")
	`ESFC_ASSERT(a_int_bound, (integral_q <= I_LIM) && (integral_q >= -I_LIM), "integral out of range")

endmodule

FILE: tb/encoder_speed_pi_frequency_control_unit_test.sv
module encoder_speed_pi_frequency_control_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import esfc_pkg::*;

	localparam int unsigned WINDOW_TICKS = 100;
	localparam int unsigned FREQ_MAX     = 5000;
	localparam int unsigned KP_GAIN      = 1400;
	localparam int unsigned KI_GAIN      = 20;

	// 0.52 speed units per count, Q16, times 100 for the window average
	localparam longint SPEED_SCALE = 3407872;
	localparam int     INTEG_LIMIT = 16384;
	localparam int     ERR_SETTLED = 65;

	localparam logic [1:0] LVL_LOW  = 2'd0;
	localparam logic [1:0] LVL_MID  = 2'd1;
	localparam logic [1:0] LVL_HIGH = 2'd2;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 300000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	esfc_stream_if #(.T(item_t))   item_if ();
	esfc_stream_if #(.T(result_t)) result_if ();

	encoder_speed_pi_frequency_control_unit #(
		.WINDOW_TICKS(WINDOW_TICKS),
		.FREQ_MAX(FREQ_MAX),
		.KP_GAIN(KP_GAIN),
		.KI_GAIN(KI_GAIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predicted block state
	logic              loop_closed;
	logic [15:0]       target_cfg [0:2];
	logic [15:0]       freq_cfg [0:2];
	logic [15:0]       last_count;
	int                tick_count;
	int                count_sum;
	logic [30:0]       speed_est;
	int                target_est;
	int                err_last;
	int                err_now;
	int                integ_est;
	logic [15:0]       freq_est;

	result_t expected_reports [$];
	item_t   queued_beats [$];

	// stimulus side mirror of the speed window, used to aim window sums
	logic [15:0] gen_count;
	int          gen_ticks;
	int          gen_sum;

	int   fail_count;
	int   cycle_count;
	bit   src_idle_on;
	bit   snk_idle_on;
	bit   hold_armed;
	int   src_gap_left;
	int   snk_stall_left;
	int   hold_left;
	logic  drv_valid;
	item_t drv_beat;
	result_t got;
	result_t want;

	function automatic int sign_int(input int v);
		if (v > 0)
			return 1;
		if (v < 0)
			return -1;
		return 0;
	endfunction

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void predict_drive_report(input item_t it);
		logic [15:0] diff;
		longint      mag;
		longint      acc;
		bit          integ_held;
		integ_held = 1'b0;
		if (it.opcode == OP_TICK) begin
			diff = last_count - it.encoder_count;
			last_count = it.encoder_count;
			count_sum += int'($signed(diff));
			tick_count = (tick_count + 1) & 'h7f;
			if (tick_count >= WINDOW_TICKS) begin
				mag = (count_sum < 0) ? -longint'(count_sum) : longint'(count_sum);
				speed_est = 31'((mag * SPEED_SCALE) / (100 * longint'(WINDOW_TICKS)));
				tick_count = 0;
				count_sum = 0;
			end
			return;
		end
		if (loop_closed) begin
			if (it.speed_level != LEVEL_KEEP)
				target_est = int'((longint'(target_cfg[it.speed_level]) * 65536 + 50) / 100);
			if (!it.run_enable)
				target_est = 0;
			err_last = err_now;
			err_now = target_est - int'({1'b0, speed_est});
			if (magnitude(err_now) <= INTEG_LIMIT) begin
				if (magnitude(integ_est) >= INTEG_LIMIT
						&& sign_int(integ_est) * sign_int(err_now) > 0) begin
					integ_held = 1'b1;
				end else begin
					integ_est += err_now;
					if (magnitude(integ_est) >= INTEG_LIMIT)
						integ_est = (integ_est > 0) ? INTEG_LIMIT : -INTEG_LIMIT;
				end
			end else begin
				integ_est = 0;
			end
			if (!integ_held && sign_int(err_last) * sign_int(err_now) < 0)
				integ_est = 0;
			acc = longint'(freq_est) * 65536 + longint'(KP_GAIN) * err_now
				+ longint'(KI_GAIN) * integ_est;
			acc = acc / 65536;
			if (magnitude(err_now) <= ERR_SETTLED)
				integ_est = 0;
			if (acc > longint'(FREQ_MAX))
				acc = FREQ_MAX;
			if (acc < 0)
				acc = 0;
			freq_est = acc[15:0];
		end else begin
			if (it.speed_level != LEVEL_KEEP)
				freq_est = freq_cfg[it.speed_level];
			if (!it.run_enable)
				freq_est = '0;
		end
		expected_reports.push_back('{drive_freq: freq_est, measured_speed: speed_est});
	endfunction

	function automatic void queue_tick(input logic [15:0] cnt);
		item_t       it;
		logic [15:0] diff;
		it.opcode = OP_TICK;
		it.encoder_count = cnt;
		it.speed_level = 2'($urandom_range(0, 3));
		it.run_enable = 1'($urandom_range(0, 1));
		queued_beats.push_back(it);
		diff = gen_count - cnt;
		gen_count = cnt;
		gen_sum += int'($signed(diff));
		gen_ticks++;
		if (gen_ticks >= WINDOW_TICKS) begin
			gen_ticks = 0;
			gen_sum = 0;
		end
	endfunction

	function automatic void queue_ctrl(input logic [1:0] level, input logic run);
		item_t it;
		it.opcode = OP_CTRL;
		it.encoder_count = 16'($urandom());
		it.speed_level = level;
		it.run_enable = run;
		queued_beats.push_back(it);
	endfunction

	function automatic void queue_random_ctrl();
		queue_ctrl(2'($urandom_range(0, 3)), $urandom_range(0, 9) != 0);
	endfunction

	// ticks up to the end of the current window, steered to a window sum of total, with random control beats mixed in
	function automatic void queue_window(input int total, input int ctrl_pct, input int jitter);
		int left;
		int step;
		do begin
			left = WINDOW_TICKS - gen_ticks;
			step = (total - gen_sum) / left;
			if (left > 1)
				step += int'($urandom_range(0, 2 * jitter)) - jitter;
			if (step > 32767)
				step = 32767;
			if (step < -32767)
				step = -32767;
			queue_tick(gen_count - 16'(step));
			if (int'($urandom_range(0, 99)) < ctrl_pct)
				queue_random_ctrl();
		end while (gen_ticks != 0);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:     loop_closed = val[0];
			REG_TGT_LOW:  target_cfg[0] = val;
			REG_TGT_MID:  target_cfg[1] = val;
			REG_TGT_HIGH: target_cfg[2] = val;
			REG_FRQ_LOW:  freq_cfg[0] = val;
			REG_FRQ_MID:  freq_cfg[1] = val;
			REG_FRQ_HIGH: freq_cfg[2] = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (queued_beats.size() != 0 || item_if.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_if.valid && item_if.ready)
				predict_drive_report(item_if.data);
			drv_valid = item_if.valid && !item_if.ready;
			drv_beat = item_if.data;
			if (!drv_valid) begin
				if (src_gap_left > 0) begin
					src_gap_left--;
				end else if (queued_beats.size() != 0) begin
					drv_beat = queued_beats.pop_front();
					drv_valid = 1'b1;
					src_gap_left = src_idle_on ? $urandom_range(0, 7) : 0;
				end
			end
			item_if.valid <= drv_valid;
			item_if.data <= drv_beat;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				got = result_if.data;
				if (expected_reports.size() == 0) begin
					$error("result beat with no expectation: drive_freq %0d measured_speed %0d",
						got.drive_freq, got.measured_speed);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (got.drive_freq !== want.drive_freq) begin
						$error("drive_freq: expected %0d, actual %0d",
							want.drive_freq, got.drive_freq);
						fail_count++;
					end
					if (got.measured_speed !== want.measured_speed) begin
						$error("measured_speed: expected %0d, actual %0d",
							want.measured_speed, got.measured_speed);
						fail_count++;
					end
				end
				snk_stall_left = snk_idle_on ? $urandom_range(0, 7) : 0;
			end
			if (hold_armed) begin
				hold_left = HOLD_CYCLES;
				hold_armed = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (snk_stall_left > 0) begin
				snk_stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int k;
		int r;
		int total;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		result_if.ready = 1'b0;
		loop_closed = 1'b0;
		for (int i = 0; i < 3; i++) begin
			target_cfg[i] = '0;
			freq_cfg[i] = '0;
		end
		last_count = '0;
		tick_count = 0;
		count_sum = 0;
		speed_est = '0;
		target_est = 0;
		err_last = 0;
		err_now = 0;
		integ_est = 0;
		freq_est = '0;
		gen_count = '0;
		gen_ticks = 0;
		gen_sum = 0;
		fail_count = 0;
		cycle_count = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		hold_armed = 1'b0;
		src_gap_left = 0;
		snk_stall_left = 0;
		hold_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, then open loop with extreme level frequencies
		queue_ctrl(LVL_LOW, 1'b1);
		wait_idle();
		write_reg(REG_FRQ_LOW, 16'hffff);
		write_reg(REG_FRQ_MID, 16'h0000);
		write_reg(REG_FRQ_HIGH, 16'd4999);
		cfg_we <= 1'b0;
		queue_ctrl(LVL_LOW, 1'b1);
		queue_ctrl(LEVEL_KEEP, 1'b1);
		queue_ctrl(LVL_MID, 1'b1);
		queue_ctrl(LVL_HIGH, 1'b0);
		queue_ctrl(LEVEL_KEEP, 1'b1);
		queue_ctrl(LVL_HIGH, 1'b1);
		queue_ctrl(LVL_LOW, 1'b1);
		queue_tick(16'h8000);
		queue_tick(16'h7fff);
		queue_tick(16'h0000);
		queue_tick(16'hffff);
		queue_tick(16'h0001);
		wait_idle();

		// closed loop: speed far below target, at target, integral build up and hold
		write_reg(REG_MODE, 1'b1);
		write_reg(REG_TGT_LOW, 16'h0000);
		write_reg(REG_TGT_MID, 16'hffff);
		write_reg(REG_TGT_HIGH, 16'd13);
		cfg_we <= 1'b0;
		queue_ctrl(LVL_MID, 1'b1);
		queue_ctrl(LVL_LOW, 1'b1);
		queue_ctrl(LVL_HIGH, 1'b1);
		queue_ctrl(LVL_HIGH, 1'b1);
		queue_ctrl(LVL_HIGH, 1'b1);
		queue_ctrl(LEVEL_KEEP, 1'b0);
		queue_ctrl(LVL_HIGH, 1'b1);
		queue_ctrl(LEVEL_KEEP, 1'b1);
		wait_idle();

		// open loop with random level frequencies
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		write_reg(REG_MODE, 1'b0);
		write_reg(REG_FRQ_LOW, 16'($urandom()));
		write_reg(REG_FRQ_MID, 16'($urandom()));
		write_reg(REG_FRQ_HIGH, 16'($urandom()));
		cfg_we <= 1'b0;
		queue_window(int'($urandom_range(0, 4000000)) - 2000000, 20, 500);
		wait_idle();

		// closed loop with targets around the measured speed
		src_idle_on = 1'b1;
		snk_idle_on = 1'b0;
		k = $urandom_range(50, 5000);
		write_reg(REG_MODE, 1'b1);
		write_reg(REG_TGT_LOW, 16'(13 * k - int'($urandom_range(0, 30))));
		write_reg(REG_TGT_MID, 16'(13 * k));
		write_reg(REG_TGT_HIGH, 16'(13 * k + int'($urandom_range(0, 30))));
		cfg_we <= 1'b0;
		total = 25 * k;
		queue_window($urandom_range(0, 1) ? total : -total, 25, 20);
		r = int'($urandom_range(0, 100)) - 50;
		queue_window($urandom_range(0, 1) ? total + r : -(total + r), 25, 20);
		repeat (8) queue_random_ctrl();
		wait_idle();

		// closed loop with extreme targets, frequency pinned at both ends
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		write_reg(REG_TGT_LOW, 16'h0000);
		write_reg(REG_TGT_MID, 16'($urandom()));
		write_reg(REG_TGT_HIGH, 16'hffff);
		cfg_we <= 1'b0;
		queue_window(int'($urandom_range(0, 6000000)) - 3000000, 30, 2000);
		wait_idle();

		// noise: random settings and random beats
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		write_reg(REG_MODE, 1'($urandom_range(0, 1)));
		write_reg(REG_TGT_LOW, 16'($urandom()));
		write_reg(REG_TGT_MID, 16'($urandom()));
		write_reg(REG_TGT_HIGH, 16'($urandom()));
		write_reg(REG_FRQ_LOW, 16'($urandom()));
		write_reg(REG_FRQ_MID, 16'($urandom()));
		write_reg(REG_FRQ_HIGH, 16'($urandom()));
		write_reg(REG_UNUSED, 16'($urandom()));
		cfg_we <= 1'b0;
		repeat (100) begin
			if ($urandom_range(0, 1))
				queue_tick(16'($urandom()));
			else
				queue_random_ctrl();
		end
		wait_idle();

		// long receiver hold while control beats keep coming
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		k = $urandom_range(50, 5000);
		write_reg(REG_MODE, 1'b1);
		write_reg(REG_TGT_MID, 16'(13 * k));
		cfg_we <= 1'b0;
		hold_armed = 1'b1;
		repeat (60) queue_random_ctrl();
		queue_window(25 * k, 10, 20);
		repeat (4) queue_random_ctrl();
		wait_idle();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
